@@ design/bcs_pkg.sv @@
// Shared constants and field layout for the bounded change search block.
package bcs_pkg;

    localparam int MAX_KINDS = 8;

    localparam int DENOM_W  = 16;
    localparam int AVAIL_W  = 8;
    localparam int TARGET_W = 24;
    localparam int KIND_W   = 3;

    // Kind pointer and kind counter widths.
    localparam int IDX_W = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;
    localparam int CNT_W = $clog2(MAX_KINDS + 1);

    // Capacity of all kinds below a pointer, and the adder width that holds
    // a partial sum plus such a capacity.
    localparam int CAP_W = TARGET_W + IDX_W;
    localparam int ALU_W = CAP_W + 1;

    // Input tdata layout, lowest bits first.
    localparam int IN_DENOM_LSB  = 0;
    localparam int IN_AVAIL_LSB  = IN_DENOM_LSB + DENOM_W;
    localparam int IN_TARGET_LSB = IN_AVAIL_LSB + AVAIL_W;
    localparam int IN_DATA_W     = ((IN_TARGET_LSB + TARGET_W + 7) / 8) * 8;

    // Output tdata layout, lowest bits first.
    localparam int OUT_KIND_LSB  = 0;
    localparam int OUT_COUNT_LSB = OUT_KIND_LSB + KIND_W;
    localparam int OUT_FOUND_LSB = OUT_COUNT_LSB + AVAIL_W;
    localparam int OUT_USED_W    = OUT_FOUND_LSB + 1;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

endpackage

@@ design/bounded_change_search.sv @@
// Bounded change search: loads coin kinds, then walks count combinations for the target.
// A transfer without tlast leaves the input ready for the next kind.
// A transfer with tlast starts the search: each visited combination is checked against the target,
// then a digit steps or carries, until a match is found or every combination is spent.
// Results then leave at one transfer per cycle while m_tready is high; no input is taken meanwhile.
// Reset (rst_n low, asynchronous) clears the sequencer, the kind counter and the target; the kind
// stores hold no reset value and need no clearing pass.
module bounded_change_search
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata fields, lowest bit up: denomination[15:0], available[23:16], target[47:24].
    input  logic [bcs_pkg::IN_DATA_W-1:0] s_tdata,
    // s_tlast carries is_last: this is the final kind and the search starts.
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata fields, lowest bit up: kind_index[2:0], chosen_count[10:3], found[11], zero fill.
    output logic [bcs_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tlast carries last_of_run.
    output logic                          m_tlast
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;  // ready for a kind transfer
    localparam logic [1:0] ST_CHECK = 2'd1;  // compare a fresh combination with the target
    localparam logic [1:0] ST_ADV   = 2'd2;  // step the digit at the pointer, or carry past it
    localparam logic [1:0] ST_OUT   = 2'd3;  // present one result transfer

    localparam int IDX_W = bcs_pkg::IDX_W;
    localparam int CNT_W = bcs_pkg::CNT_W;
    localparam int CAP_W = bcs_pkg::CAP_W;
    localparam int ALU_W = bcs_pkg::ALU_W;
    localparam int TGT_W = bcs_pkg::TARGET_W;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] kinds_reg, kinds_next;
    logic [CNT_W-1:0] num_reg, num_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [TGT_W-1:0] target_reg, target_next;
    logic [TGT_W-1:0] sum_reg, sum_next;
    logic [CAP_W-1:0] cap_acc_reg, cap_acc_next;
    logic             found_reg, found_next;

    // Per-kind stores. The capacity entry of a kind is the largest sum that the kinds below
    // it can make; the base entry is the running sum with this digit and all below it at zero.
    logic [bcs_pkg::DENOM_W-1:0] denom_reg [bcs_pkg::MAX_KINDS];
    logic [bcs_pkg::AVAIL_W-1:0] avail_reg [bcs_pkg::MAX_KINDS];
    logic [CAP_W-1:0]            cap_reg   [bcs_pkg::MAX_KINDS];
    logic [bcs_pkg::AVAIL_W-1:0] digit_reg [bcs_pkg::MAX_KINDS];
    logic [TGT_W-1:0]            base_reg  [bcs_pkg::MAX_KINDS];

    logic [bcs_pkg::DENOM_W-1:0] in_denom;
    logic [bcs_pkg::AVAIL_W-1:0] in_avail;
    logic [TGT_W-1:0]            in_target;
    logic                        accept;
    logic                        room;
    logic                        search_start;
    logic [TGT_W-1:0]            load_prod;

    logic [ALU_W-1:0]            alu_opnd;
    logic [ALU_W-1:0]            alu_sum;
    logic                        can_step;
    logic                        ptr_is_top;

    assign in_denom  = s_tdata[bcs_pkg::IN_DENOM_LSB  +: bcs_pkg::DENOM_W];
    assign in_avail  = s_tdata[bcs_pkg::IN_AVAIL_LSB  +: bcs_pkg::AVAIL_W];
    assign in_target = s_tdata[bcs_pkg::IN_TARGET_LSB +: TGT_W];

    assign s_tready     = (state_reg == ST_IDLE);
    assign accept       = s_tvalid && s_tready;
    assign room         = (kinds_reg < CNT_W'(bcs_pkg::MAX_KINDS));
    assign search_start = accept && s_tlast;

    // Full capacity of the kind being loaded; it fits the target width.
    assign load_prod = TGT_W'(in_denom * in_avail);

    // The one shared adder: partial sum plus either the capacity below the pointer (when a
    // combination is checked) or the denomination at the pointer (when a digit steps).
    always_comb
    begin
        if (state_reg == ST_CHECK)
        begin
            alu_opnd = ALU_W'(cap_reg[ptr_reg]);
        end
        else
        begin
            alu_opnd = ALU_W'(denom_reg[ptr_reg]);
        end
        alu_sum = ALU_W'(sum_reg) + alu_opnd;
    end

    // A digit steps only while coins remain and the sum stays within the target; once the sum
    // would pass the target, no larger count of this digit can help, so the walk carries.
    assign can_step   = (digit_reg[ptr_reg] != avail_reg[ptr_reg]) &&
                        (alu_sum <= ALU_W'(target_reg));
    assign ptr_is_top = ((CNT_W'(ptr_reg) + CNT_W'(1)) == num_reg);

    always_comb
    begin
        state_next   = state_reg;
        kinds_next   = kinds_reg;
        num_next     = num_reg;
        ptr_next     = ptr_reg;
        target_next  = target_reg;
        sum_next     = sum_reg;
        cap_acc_next = cap_acc_reg;
        found_next   = found_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        kinds_next   = kinds_reg + CNT_W'(1);
                        cap_acc_next = cap_acc_reg + CAP_W'(load_prod);
                    end
                    if (s_tlast)
                    begin
                        // Start from all digits at zero; the next item begins a new run.
                        num_next     = room ? (kinds_reg + CNT_W'(1)) : kinds_reg;
                        kinds_next   = '0;
                        cap_acc_next = '0;
                        target_next  = in_target;
                        sum_next     = '0;
                        ptr_next     = '0;
                        state_next   = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                // Digits below the pointer are zero here.
                if (sum_reg == target_reg)
                begin
                    found_next = 1'b1;
                    ptr_next   = '0;
                    state_next = ST_OUT;
                end
                else if (alu_sum < ALU_W'(target_reg))
                begin
                    // Lower kinds cannot close the gap: step this digit directly.
                    state_next = ST_ADV;
                end
                else
                begin
                    ptr_next   = '0;
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (can_step)
                begin
                    sum_next   = alu_sum[TGT_W-1:0];
                    state_next = ST_CHECK;
                end
                else
                begin
                    sum_next = base_reg[ptr_reg];
                    if (ptr_is_top)
                    begin
                        // Carry out of the top digit: every combination is spent.
                        found_next = 1'b0;
                        ptr_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + IDX_W'(1);
                    end
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (m_tlast)
                    begin
                        ptr_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kinds_reg   <= '0;
            num_reg     <= '0;
            ptr_reg     <= '0;
            target_reg  <= '0;
            sum_reg     <= '0;
            cap_acc_reg <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kinds_reg   <= kinds_next;
            num_reg     <= num_next;
            ptr_reg     <= ptr_next;
            target_reg  <= target_next;
            sum_reg     <= sum_next;
            cap_acc_reg <= cap_acc_next;
            found_reg   <= found_next;
        end
    end

    // Kind stores, written once per loaded kind.
    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            denom_reg[kinds_reg[IDX_W-1:0]] <= in_denom;
            avail_reg[kinds_reg[IDX_W-1:0]] <= in_avail;
            cap_reg[kinds_reg[IDX_W-1:0]]   <= cap_acc_reg;
        end
    end

    // Digit counters and base sums. A step at the pointer leaves the lower digits at zero,
    // so the new sum is the base for every digit below it.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < bcs_pkg::MAX_KINDS; i++)
        begin
            if (search_start)
            begin
                digit_reg[i] <= '0;
                base_reg[i]  <= '0;
            end
            else if (state_reg == ST_ADV)
            begin
                if (IDX_W'(i) == ptr_reg)
                begin
                    digit_reg[i] <= can_step ? (digit_reg[i] + 8'd1) : '0;
                end
                if (can_step && (IDX_W'(i) < ptr_reg))
                begin
                    base_reg[i] <= alu_sum[TGT_W-1:0];
                end
            end
        end
    end

    // Result transfers: one per loaded kind on success, a single empty one otherwise.
    always_comb
    begin
        m_tdata  = '0;
        m_tvalid = (state_reg == ST_OUT);
        m_tlast  = !found_reg || ptr_is_top;
        if (found_reg)
        begin
            m_tdata[bcs_pkg::OUT_KIND_LSB  +: bcs_pkg::KIND_W]  = bcs_pkg::KIND_W'(ptr_reg);
            m_tdata[bcs_pkg::OUT_COUNT_LSB +: bcs_pkg::AVAIL_W] = digit_reg[ptr_reg];
            m_tdata[bcs_pkg::OUT_FOUND_LSB]                     = 1'b1;
        end
    end

    // The running sum never passes the target of the current search.
    a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg <= target_reg))
        else $error("running sum passed the target");

    // During the walk and the output the pointer stays inside the loaded kinds.
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (CNT_W'(ptr_reg) < num_reg))
        else $error("kind pointer outside loaded kinds");

    // A failed search gives exactly one transfer.
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !found_reg) |-> m_tlast)
        else $error("no-solution result not marked last");

    // Input and output are never both open.
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    // A found result has a sum equal to the target once the walk stops.
    a_found_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && found_reg) |-> (sum_reg == target_reg))
        else $error("reported solution does not match the target");

endmodule
